@@ rtl/tmsg_pkg.sv @@
// ----------------------------------------------------------------------------
// Text-mode scanline generator package
// Shared widths, operation codes, register indexes, defaults and FSM type.
// ----------------------------------------------------------------------------
package tmsg_pkg;

    localparam int MEM_DEPTH    = 2048;
    localparam int ADDR_W       = 11;
    localparam int BYTE_W       = 8;
    localparam int OP_W         = 2;
    localparam int LINE_W       = 8;
    localparam int PIX_W        = 64;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 8;
    localparam int ROW_W        = 6;
    localparam int GLYPH_ROW_W  = 3;

    // Defaults for the top-level parameters
    localparam int DEF_COLUMNS      = 64;
    localparam int DEF_TEXT_ROWS    = 32;
    localparam int DEF_BORDER_WORDS = 16;

    // Operation codes of the request channel
    localparam logic [OP_W-1:0] OP_WRITE_CELL = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE_FONT = 2'd1;
    localparam logic [OP_W-1:0] OP_RENDER     = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_BACKGROUND = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FOREGROUND = 1'd1;

    localparam logic [BYTE_W-1:0] BACKGROUND_RESET = 8'd0;
    localparam logic [BYTE_W-1:0] FOREGROUND_RESET = 8'd182;

    typedef enum logic
    {
        ST_IDLE,
        ST_RENDER
    } seq_state_t;

endpackage

@@ rtl/tmsg_in_if.sv @@
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one write or render request.
// ----------------------------------------------------------------------------
interface tmsg_in_if;

    logic                              valid;
    logic                              ready;
    logic [tmsg_pkg::OP_W-1:0]         operation;
    logic [tmsg_pkg::ADDR_W-1:0]       address;
    logic [tmsg_pkg::BYTE_W-1:0]       data_byte;
    logic [tmsg_pkg::LINE_W-1:0]       line;

    modport source
    (
        output valid,
        input  ready,
        output operation,
        output address,
        output data_byte,
        output line
    );

    modport sink
    (
        input  valid,
        output ready,
        input  operation,
        input  address,
        input  data_byte,
        input  line
    );

endinterface

@@ rtl/tmsg_out_if.sv @@
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one group of sixteen pixels.
// ----------------------------------------------------------------------------
interface tmsg_out_if;

    logic                              valid;
    logic                              ready;
    logic [tmsg_pkg::PIX_W-1:0]        pixels_first;
    logic [tmsg_pkg::PIX_W-1:0]        pixels_second;
    logic                              last;

    modport source
    (
        output valid,
        input  ready,
        output pixels_first,
        output pixels_second,
        output last
    );

    modport sink
    (
        input  valid,
        output ready,
        input  pixels_first,
        input  pixels_second,
        input  last
    );

endinterface

@@ rtl/text_mode_scanline_generator_top.sv @@
// ----------------------------------------------------------------------------
// Text-mode scanline generator
// Character and font memories with a three-stage render pipeline.
// ----------------------------------------------------------------------------
// A write request (cell or font byte) gives no result. A render request
// gives BORDER_WORDS/4 border groups, COLUMNS/2 character groups and
// BORDER_WORDS/4 border groups again, the final one flagged with last: 40
// groups with the default parameters. The pipeline issues one group per
// cycle while the result side takes every transfer; a stalled output holds
// it. Each group passes the stages character memory read, font memory read
// and output register, in that order. The rate is set by the single group
// issued per cycle into the two-address reads of the character and font
// memories. A new request is taken once the last group of a render has
// passed the font read. Neither memory is cleared: cells and glyph bytes
// must be written before they are rendered.
// ----------------------------------------------------------------------------
module text_mode_scanline_generator_top
#(
    parameter int COLUMNS      = tmsg_pkg::DEF_COLUMNS,
    parameter int TEXT_ROWS    = tmsg_pkg::DEF_TEXT_ROWS,
    parameter int BORDER_WORDS = tmsg_pkg::DEF_BORDER_WORDS
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [tmsg_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tmsg_pkg::CFG_DATA_W-1:0]     cfg_data,
    tmsg_in_if.sink                             request,
    tmsg_out_if.source                          result
);

    localparam int BORDER_RESULTS = BORDER_WORDS / 4;
    localparam int CHAR_RESULTS   = COLUMNS / 2;
    localparam int TOTAL_RESULTS  = 2 * BORDER_RESULTS + CHAR_RESULTS;
    localparam int K_W            = $clog2(TOTAL_RESULTS + 1);
    localparam int COL_W          = $clog2(COLUMNS);
    localparam int LUT_DEPTH      = 2 ** (tmsg_pkg::LINE_W - tmsg_pkg::GLYPH_ROW_W);

    localparam logic [K_W-1:0] K_LAST       = K_W'(TOTAL_RESULTS - 1);
    localparam logic [K_W-1:0] K_CHAR_FIRST = K_W'(BORDER_RESULTS);
    localparam logic [K_W-1:0] K_CHAR_END   = K_W'(BORDER_RESULTS + CHAR_RESULTS);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [tmsg_pkg::BYTE_W-1:0] bg_reg;
    logic [tmsg_pkg::BYTE_W-1:0] fg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bg_reg <= tmsg_pkg::BACKGROUND_RESET;
            fg_reg <= tmsg_pkg::FOREGROUND_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tmsg_pkg::CFG_BACKGROUND: bg_reg <= cfg_data;
                tmsg_pkg::CFG_FOREGROUND: fg_reg <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Text row table: (line / 8) modulo TEXT_ROWS, worked out at
    // elaboration for every possible row number.
    // ------------------------------------------------------------------
    logic [tmsg_pkg::ROW_W-1:0] row_lut [LUT_DEPTH];

    for (genvar g = 0; g < LUT_DEPTH; g++)
    begin : g_row_lut
        assign row_lut[g] = tmsg_pkg::ROW_W'(g % TEXT_ROWS);
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    tmsg_pkg::seq_state_t state_reg, state_next;

    logic [K_W-1:0]                     k_reg, k_next;
    logic [COL_W-1:0]                   col_reg, col_next;
    logic [tmsg_pkg::ADDR_W-1:0]        base_reg, base_next;
    logic [tmsg_pkg::GLYPH_ROW_W-1:0]   glyph_row_reg, glyph_row_next;

    logic accept;
    logic render_accept;
    logic advance;
    logic issue;
    logic issue_border;
    logic issue_last;
    logic in_ready;

    // Pipeline valid and tag bits
    logic p1_valid_reg, p1_border_reg, p1_last_reg;
    logic p2_valid_reg, p2_border_reg, p2_last_reg;
    logic out_valid_reg;

    // The whole pipeline moves when the output register is free or drains
    assign advance       = !out_valid_reg || result.ready;
    assign accept        = request.valid && in_ready;
    assign render_accept = accept && (request.operation == tmsg_pkg::OP_RENDER);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tmsg_pkg::ST_IDLE:
            begin
                if (render_accept)
                begin
                    state_next = tmsg_pkg::ST_RENDER;
                end
            end
            tmsg_pkg::ST_RENDER:
            begin
                if (issue && (k_reg == K_LAST))
                begin
                    state_next = tmsg_pkg::ST_IDLE;
                end
            end
            default: state_next = tmsg_pkg::ST_IDLE;
        endcase
    end

    // Outputs: take requests only when idle and no font read is pending,
    // so a font write never overtakes the last read of a render.
    always_comb
    begin
        in_ready = 1'b0;
        issue    = 1'b0;
        case (state_reg)
            tmsg_pkg::ST_IDLE:   in_ready = !p1_valid_reg;
            tmsg_pkg::ST_RENDER: issue    = advance;
            default:             ;
        endcase
    end

    assign request.ready = in_ready;

    assign issue_border = (k_reg < K_CHAR_FIRST) || (k_reg >= K_CHAR_END);
    assign issue_last   = (k_reg == K_LAST);

    // Counters and render context
    always_comb
    begin
        k_next         = k_reg;
        col_next       = col_reg;
        base_next      = base_reg;
        glyph_row_next = glyph_row_reg;
        if (render_accept)
        begin
            k_next         = '0;
            col_next       = '0;
            glyph_row_next = request.line[tmsg_pkg::GLYPH_ROW_W-1:0];
            base_next      = tmsg_pkg::ADDR_W'(
                row_lut[request.line[tmsg_pkg::LINE_W-1:tmsg_pkg::GLYPH_ROW_W]] * COLUMNS);
        end
        else if (issue)
        begin
            k_next = k_reg + K_W'(1);
            if (!issue_border)
            begin
                col_next = col_reg + COL_W'(2);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tmsg_pkg::ST_IDLE;
            k_reg     <= '0;
            col_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            col_reg   <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg      <= base_next;
        glyph_row_reg <= glyph_row_next;
    end

    // ------------------------------------------------------------------
    // Character memory: one write port, two read ports for a column pair
    // ------------------------------------------------------------------
    logic [tmsg_pkg::BYTE_W-1:0] char_mem [tmsg_pkg::MEM_DEPTH];
    logic [tmsg_pkg::BYTE_W-1:0] char_rd0_reg, char_rd1_reg;
    logic [tmsg_pkg::ADDR_W-1:0] cell_addr0, cell_addr1;
    logic                        char_we, char_re;

    assign char_we    = accept && (request.operation == tmsg_pkg::OP_WRITE_CELL);
    assign char_re    = issue && !issue_border;
    assign cell_addr0 = base_reg + tmsg_pkg::ADDR_W'(col_reg);
    assign cell_addr1 = base_reg + tmsg_pkg::ADDR_W'(col_reg) + tmsg_pkg::ADDR_W'(1);

    always_ff @(posedge clk)
    begin
        if (char_we)
        begin
            char_mem[request.address] <= request.data_byte;
        end
        if (char_re)
        begin
            char_rd0_reg <= char_mem[cell_addr0];
            char_rd1_reg <= char_mem[cell_addr1];
        end
    end

    // ------------------------------------------------------------------
    // Font memory: glyph byte at code*8 + glyph row for both characters
    // ------------------------------------------------------------------
    logic [tmsg_pkg::BYTE_W-1:0] font_mem [tmsg_pkg::MEM_DEPTH];
    logic [tmsg_pkg::BYTE_W-1:0] font_rd0_reg, font_rd1_reg;
    logic                        font_we, font_re;

    assign font_we = accept && (request.operation == tmsg_pkg::OP_WRITE_FONT);
    assign font_re = advance && p1_valid_reg && !p1_border_reg;

    always_ff @(posedge clk)
    begin
        if (font_we)
        begin
            font_mem[request.address] <= request.data_byte;
        end
        if (font_re)
        begin
            font_rd0_reg <= font_mem[{char_rd0_reg, glyph_row_reg}];
            font_rd1_reg <= font_mem[{char_rd1_reg, glyph_row_reg}];
        end
    end

    // ------------------------------------------------------------------
    // Pipeline tags: hold on a stalled output, advance otherwise
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            p1_border_reg <= 1'b0;
            p1_last_reg   <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p2_border_reg <= 1'b0;
            p2_last_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            p1_valid_reg  <= issue;
            p1_border_reg <= issue_border;
            p1_last_reg   <= issue_last;
            p2_valid_reg  <= p1_valid_reg;
            p2_border_reg <= p1_border_reg;
            p2_last_reg   <= p1_last_reg;
            out_valid_reg <= p2_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Glyph expansion into the output register
    // ------------------------------------------------------------------
    function automatic logic [tmsg_pkg::PIX_W-1:0] expand_glyph
    (
        input logic [tmsg_pkg::BYTE_W-1:0] pattern,
        input logic [tmsg_pkg::BYTE_W-1:0] fg,
        input logic [tmsg_pkg::BYTE_W-1:0] bg
    );
        logic [tmsg_pkg::PIX_W-1:0] word;
        word = '0;
        // Bit 7 is the leftmost pixel, placed in the lowest byte
        for (int n = 0; n < 8; n++)
        begin
            word[8*n +: 8] = pattern[7-n] ? fg : bg;
        end
        return word;
    endfunction

    logic [tmsg_pkg::PIX_W-1:0] out_first_reg, out_second_reg;
    logic                       out_last_reg;
    logic [tmsg_pkg::PIX_W-1:0] bg_fill;

    assign bg_fill = {8{bg_reg}};

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_last_reg <= p2_last_reg;
            if (p2_border_reg)
            begin
                out_first_reg  <= bg_fill;
                out_second_reg <= bg_fill;
            end
            else
            begin
                out_first_reg  <= expand_glyph(font_rd0_reg, fg_reg, bg_reg);
                out_second_reg <= expand_glyph(font_rd1_reg, fg_reg, bg_reg);
            end
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.pixels_first  = out_first_reg;
    assign result.pixels_second = out_second_reg;
    assign result.last          = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_char_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(char_we && char_re))
        else $error("character write overlaps a character read");

    a_font_no_pending_write: assert property (@(posedge clk) disable iff (!rst_n)
        font_we |-> !p1_valid_reg)
        else $error("font write while a font read is pending");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        char_re |-> (32'(col_reg) + 1 < COLUMNS))
        else $error("column pair beyond the row");

    a_stall_holds_p2: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready && p2_valid_reg) |=> p2_valid_reg)
        else $error("pipeline group lost during stall");

    a_render_ends_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tmsg_pkg::ST_RENDER && state_next == tmsg_pkg::ST_IDLE)
            |=> (p1_valid_reg && p1_last_reg))
        else $error("render ended without a last group");

endmodule

@@ tb/text_mode_scanline_generator_top_tb.sv @@
// ----------------------------------------------------------------------------
// Text-mode scanline generator testbench
// Loads cells and glyph bytes, renders lines under several colour settings,
// and checks every pixel group against a line predictor kept in step with
// each accepted request. Both channels idle and stall at random, and one long
// result hold-off backs the block up into its request channel.
// ----------------------------------------------------------------------------
module text_mode_scanline_generator_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLUMNS      = tmsg_pkg::DEF_COLUMNS;
    localparam int TEXT_ROWS    = tmsg_pkg::DEF_TEXT_ROWS;
    localparam int BORDER_WORDS = tmsg_pkg::DEF_BORDER_WORDS;

    // The request channel has no code for the fourth operation; the block
    // must swallow it without effect.
    localparam logic [tmsg_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    // Cycles to let pass after the last group before touching the colours:
    // covers a trailing write still in the pipeline.
    localparam int SETTLE_CYCLES = 8;

    // Rows that the preload fills completely with codes from the glyph pool.
    localparam int TOP_ROW    = 0;
    localparam int BOTTOM_ROW = TEXT_ROWS - 1;

    // Number of glyph codes whose every glyph row gets loaded.
    localparam int POOL_SIZE = 4;

    typedef struct packed
    {
        logic [tmsg_pkg::OP_W-1:0]   operation;
        logic [tmsg_pkg::ADDR_W-1:0] address;
        logic [tmsg_pkg::BYTE_W-1:0] data_byte;
        logic [tmsg_pkg::LINE_W-1:0] line;
    } request_t;

    typedef struct packed
    {
        logic [tmsg_pkg::PIX_W-1:0] pixels_first;
        logic [tmsg_pkg::PIX_W-1:0] pixels_second;
        logic                       last;
    } pixel_group_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [tmsg_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [tmsg_pkg::CFG_DATA_W-1:0]  cfg_data;

    tmsg_in_if  req_if();
    tmsg_out_if res_if();

    text_mode_scanline_generator_top
    #(
        .COLUMNS      (COLUMNS),
        .TEXT_ROWS    (TEXT_ROWS),
        .BORDER_WORDS (BORDER_WORDS)
    )
    dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .request   (req_if),
        .result    (res_if)
    );

    // Requests waiting for the driver, and pixel groups owed by the block.
    request_t     requests_pending[$];
    pixel_group_t groups_due[$];

    // Line predictor state: mirrors of both memories and the colour pair,
    // updated only when a request or a colour write actually lands.
    logic [tmsg_pkg::BYTE_W-1:0] cell_mem [0:tmsg_pkg::MEM_DEPTH-1];
    logic [tmsg_pkg::BYTE_W-1:0] font_mem [0:tmsg_pkg::MEM_DEPTH-1];
    logic [tmsg_pkg::BYTE_W-1:0] bg_colour;
    logic [tmsg_pkg::BYTE_W-1:0] fg_colour;

    // Generator bookkeeping: what the queued stream will have written by the
    // time each request lands. Renders are only issued for lines whose cells
    // and glyph bytes are all covered.
    bit                          cell_planned [0:tmsg_pkg::MEM_DEPTH-1];
    logic [tmsg_pkg::BYTE_W-1:0] cell_plan    [0:tmsg_pkg::MEM_DEPTH-1];
    bit                          font_planned [0:tmsg_pkg::MEM_DEPTH-1];
    logic [tmsg_pkg::BYTE_W-1:0] glyph_pool   [0:POOL_SIZE-1];

    int       errors;
    int       send_idle_pct;
    int       recv_idle_pct;
    int       phase_no;
    logic     hold_off;
    request_t offered;
    pixel_group_t wanted;

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    always #10 clk = ~clk;

    // ------------------------------------------------------------------------
    // Line predictor
    // ------------------------------------------------------------------------

    // Spread one font byte over eight pixels; bit 7 lands in the lowest byte.
    function automatic logic [tmsg_pkg::PIX_W-1:0] expand_pattern(
        logic [tmsg_pkg::BYTE_W-1:0] pattern);
        logic [tmsg_pkg::PIX_W-1:0] word;
        word = '0;
        for (int k = 0; k < 8; k++)
        begin
            word[8*k +: 8] = pattern[7-k] ? fg_colour : bg_colour;
        end
        return word;
    endfunction

    task automatic predict_render(logic [tmsg_pkg::LINE_W-1:0] line_no);
        logic [tmsg_pkg::GLYPH_ROW_W-1:0] glyph_row;
        int                               base;
        logic [tmsg_pkg::ADDR_W-1:0]      cell0;
        logic [tmsg_pkg::ADDR_W-1:0]      cell1;
        pixel_group_t                     grp;
        glyph_row = line_no[2:0];
        // Wrap the text row to the screen, then the cell index to the memory.
        base = ((line_no >> 3) % TEXT_ROWS) * COLUMNS;
        grp.pixels_first  = {8{bg_colour}};
        grp.pixels_second = {8{bg_colour}};
        grp.last          = 1'b0;
        for (int i = 0; i < BORDER_WORDS / 4; i++)
        begin
            groups_due.push_back(grp);
        end
        for (int i = 0; i + 1 < COLUMNS; i += 2)
        begin
            cell0 = tmsg_pkg::ADDR_W'(base + i);
            cell1 = tmsg_pkg::ADDR_W'(base + i + 1);
            grp.pixels_first  = expand_pattern(font_mem[{cell_mem[cell0], glyph_row}]);
            grp.pixels_second = expand_pattern(font_mem[{cell_mem[cell1], glyph_row}]);
            groups_due.push_back(grp);
        end
        grp.pixels_first  = {8{bg_colour}};
        grp.pixels_second = {8{bg_colour}};
        for (int i = 0; i < BORDER_WORDS / 4; i++)
        begin
            groups_due.push_back(grp);
        end
        // Flag the closing group of the line.
        grp = groups_due.pop_back();
        grp.last = 1'b1;
        groups_due.push_back(grp);
    endtask

    task automatic apply_request(request_t req);
        case (req.operation)
            tmsg_pkg::OP_WRITE_CELL: cell_mem[req.address] = req.data_byte;
            tmsg_pkg::OP_WRITE_FONT: font_mem[req.address] = req.data_byte;
            tmsg_pkg::OP_RENDER:     predict_render(req.line);
            default:                 ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------------

    // Queue one request and record which memory entries it will have filled.
    task automatic queue_request(logic [tmsg_pkg::OP_W-1:0] op,
                                 logic [tmsg_pkg::ADDR_W-1:0] addr,
                                 logic [tmsg_pkg::BYTE_W-1:0] data,
                                 logic [tmsg_pkg::LINE_W-1:0] line_no);
        request_t req;
        req.operation = op;
        req.address   = addr;
        req.data_byte = data;
        req.line      = line_no;
        if (op == tmsg_pkg::OP_WRITE_CELL)
        begin
            cell_planned[addr] = 1'b1;
            cell_plan[addr]    = data;
        end
        else if (op == tmsg_pkg::OP_WRITE_FONT)
        begin
            font_planned[addr] = 1'b1;
        end
        requests_pending.push_back(req);
    endtask

    // True when every cell of the line's row and every glyph byte it needs
    // will have been written.
    function automatic bit line_covered(logic [tmsg_pkg::LINE_W-1:0] line_no);
        int                          base;
        logic [tmsg_pkg::ADDR_W-1:0] idx;
        base = ((line_no >> 3) % TEXT_ROWS) * COLUMNS;
        for (int c = 0; c < COLUMNS; c++)
        begin
            idx = tmsg_pkg::ADDR_W'(base + c);
            if (!cell_planned[idx] || !font_planned[{cell_plan[idx], line_no[2:0]}])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Try a few lines anywhere on screen, then fall back to a preloaded row,
    // which only ever holds pool codes and so stays renderable.
    function automatic logic [tmsg_pkg::LINE_W-1:0] pick_render_line();
        logic [tmsg_pkg::LINE_W-1:0] line_no;
        for (int t = 0; t < 8; t++)
        begin
            line_no = tmsg_pkg::LINE_W'($urandom_range(0, 255));
            if (line_covered(line_no))
                return line_no;
        end
        line_no[2:0] = tmsg_pkg::GLYPH_ROW_W'($urandom_range(0, 7));
        line_no[7:3] = $urandom_range(0, 1) ? 5'(BOTTOM_ROW) : 5'(TOP_ROW);
        return line_no;
    endfunction

    function automatic logic [tmsg_pkg::BYTE_W-1:0] pool_code();
        return glyph_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // Fill every glyph row of the pool codes and the two preloaded rows.
    task automatic queue_preload();
        for (int g = 0; g < POOL_SIZE; g++)
        begin
            for (int r = 0; r < 8; r++)
            begin
                queue_request(tmsg_pkg::OP_WRITE_FONT, {glyph_pool[g], 3'(r)},
                              tmsg_pkg::BYTE_W'($urandom_range(0, 255)),
                              tmsg_pkg::LINE_W'($urandom_range(0, 255)));
            end
        end
        for (int c = 0; c < COLUMNS; c++)
        begin
            queue_request(tmsg_pkg::OP_WRITE_CELL,
                          tmsg_pkg::ADDR_W'(TOP_ROW * COLUMNS + c), pool_code(),
                          tmsg_pkg::LINE_W'($urandom_range(0, 255)));
            queue_request(tmsg_pkg::OP_WRITE_CELL,
                          tmsg_pkg::ADDR_W'(BOTTOM_ROW * COLUMNS + c), pool_code(),
                          tmsg_pkg::LINE_W'($urandom_range(0, 255)));
        end
    endtask

    // Field extremes, every operation, ignored fields set, unused operation.
    task automatic queue_directed();
        // Corner cells: code 0 at the first cell, code 255 at the last.
        queue_request(tmsg_pkg::OP_WRITE_CELL, 11'd0, 8'h00, 8'hff);
        queue_request(tmsg_pkg::OP_WRITE_CELL, 11'd2047, 8'hff, 8'h00);
        // Glyph bytes at both ends of the font memory and single-pixel edges.
        queue_request(tmsg_pkg::OP_WRITE_FONT, 11'd0, 8'h00, 8'hff);
        queue_request(tmsg_pkg::OP_WRITE_FONT, 11'd2047, 8'hff, 8'h00);
        queue_request(tmsg_pkg::OP_WRITE_FONT, {8'hff, 3'd0}, 8'h80, 8'h00);
        queue_request(tmsg_pkg::OP_WRITE_FONT, {8'h00, 3'd7}, 8'h01, 8'h00);
        // Renders ignore address and data: drive them at both extremes.
        queue_request(tmsg_pkg::OP_RENDER, 11'd2047, 8'hff, 8'd0);
        queue_request(tmsg_pkg::OP_RENDER, 11'd0, 8'h00, 8'd7);
        queue_request(tmsg_pkg::OP_RENDER, 11'd2047, 8'h00, 8'd255);
        queue_request(tmsg_pkg::OP_RENDER, 11'd0, 8'hff, 8'd248);
        // Unused operation: no result and no memory change.
        queue_request(OP_UNUSED, 11'd2047, 8'hff, 8'hff);
        queue_request(OP_UNUSED, 11'd0, 8'h00, 8'h00);
        queue_request(OP_UNUSED, 11'(TOP_ROW * COLUMNS), 8'h55, 8'd0);
        queue_request(tmsg_pkg::OP_RENDER, 11'd0, 8'h00, 8'd0);
        queue_request(tmsg_pkg::OP_RENDER, 11'd1234, 8'h5a, 8'd3);
        queue_request(tmsg_pkg::OP_RENDER, 11'd700, 8'ha5, 8'd252);
    endtask

    // Random mix: renders of covered lines, writes that keep the preloaded
    // rows renderable, noise writes elsewhere, and the unused operation.
    task automatic queue_random(int count);
        int made;
        int pick;
        made = 0;
        while (made < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                queue_request(tmsg_pkg::OP_RENDER,
                              tmsg_pkg::ADDR_W'($urandom_range(0, 2047)),
                              tmsg_pkg::BYTE_W'($urandom_range(0, 255)),
                              pick_render_line());
                made++;
            end
            else if (pick < 60)
            begin
                if ($urandom_range(0, 9) < 7)
                    queue_request(tmsg_pkg::OP_WRITE_CELL,
                                  tmsg_pkg::ADDR_W'(
                                      ($urandom_range(0, 1) ? BOTTOM_ROW : TOP_ROW) * COLUMNS
                                      + $urandom_range(0, COLUMNS - 1)),
                                  pool_code(), tmsg_pkg::LINE_W'($urandom_range(0, 255)));
                else
                    // Keep noise off the preloaded rows.
                    queue_request(tmsg_pkg::OP_WRITE_CELL,
                                  tmsg_pkg::ADDR_W'($urandom_range((TOP_ROW + 1) * COLUMNS,
                                                                   BOTTOM_ROW * COLUMNS - 1)),
                                  tmsg_pkg::BYTE_W'($urandom_range(0, 255)),
                                  tmsg_pkg::LINE_W'($urandom_range(0, 255)));
                made++;
            end
            else if (pick < 85)
            begin
                if ($urandom_range(0, 9) < 6)
                    queue_request(tmsg_pkg::OP_WRITE_FONT,
                                  {pool_code(), 3'($urandom_range(0, 7))},
                                  tmsg_pkg::BYTE_W'($urandom_range(0, 255)),
                                  tmsg_pkg::LINE_W'($urandom_range(0, 255)));
                else
                    queue_request(tmsg_pkg::OP_WRITE_FONT,
                                  tmsg_pkg::ADDR_W'($urandom_range(0, 2047)),
                                  tmsg_pkg::BYTE_W'($urandom_range(0, 255)),
                                  tmsg_pkg::LINE_W'($urandom_range(0, 255)));
                made++;
            end
            else
            begin
                queue_request(OP_UNUSED, tmsg_pkg::ADDR_W'($urandom_range(0, 2047)),
                              tmsg_pkg::BYTE_W'($urandom_range(0, 255)),
                              tmsg_pkg::LINE_W'($urandom_range(0, 255)));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Phase control
    // ------------------------------------------------------------------------

    // Hold until every request has landed and every group has come back, then
    // let a trailing write clear the pipeline.
    task automatic wait_idle();
        while (requests_pending.size() != 0 || req_if.valid || groups_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_colour(logic [tmsg_pkg::CFG_INDEX_W-1:0] index,
                                logic [tmsg_pkg::CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (index)
            tmsg_pkg::CFG_BACKGROUND: bg_colour = value;
            tmsg_pkg::CFG_FOREGROUND: fg_colour = value;
            default:                  ;
        endcase
    endtask

    task automatic start_phase(int number, int send_pct, int recv_pct);
        @(negedge clk);
        phase_no      = number;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    initial
    begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = tmsg_pkg::CFG_BACKGROUND;
        cfg_data  = '0;
        req_if.valid     = 1'b0;
        req_if.operation = tmsg_pkg::OP_WRITE_CELL;
        req_if.address   = '0;
        req_if.data_byte = '0;
        req_if.line      = '0;
        res_if.ready     = 1'b0;
        hold_off      = 1'b0;
        errors        = 0;
        phase_no      = 0;
        send_idle_pct = 13;
        recv_idle_pct = 74;
        bg_colour     = tmsg_pkg::BACKGROUND_RESET;
        fg_colour     = tmsg_pkg::FOREGROUND_RESET;
        glyph_pool[0] = 8'h00;
        glyph_pool[1] = 8'hff;
        glyph_pool[2] = 8'h55;
        glyph_pool[3] = 8'haa;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset colours: load memories, then the directed set.
        start_phase(0, 13, 74);
        queue_preload();
        queue_directed();
        wait_idle();

        // Light sender gaps, heavy result stalls; white on black inverted.
        write_colour(tmsg_pkg::CFG_BACKGROUND, 8'hff);
        write_colour(tmsg_pkg::CFG_FOREGROUND, 8'h00);
        start_phase(1, 13, 74);
        queue_random(15);
        wait_idle();

        // Swap the idling: heavy sender gaps, light result stalls.
        write_colour(tmsg_pkg::CFG_BACKGROUND, 8'h00);
        write_colour(tmsg_pkg::CFG_FOREGROUND, 8'hff);
        start_phase(2, 74, 13);
        queue_random(15);
        wait_idle();

        // Full rate on both sides, random colours; the long hold-off lands here.
        write_colour(tmsg_pkg::CFG_BACKGROUND,
                     tmsg_pkg::CFG_DATA_W'($urandom_range(0, 255)));
        write_colour(tmsg_pkg::CFG_FOREGROUND,
                     tmsg_pkg::CFG_DATA_W'($urandom_range(0, 255)));
        start_phase(3, 0, 0);
        // Open with a render so the hold-off backs it up into the requests.
        queue_request(tmsg_pkg::OP_RENDER, '0, '0, pick_render_line());
        queue_random(15);
        wait_idle();

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Back up the block: drop ready for a long stretch while the sender keeps
    // offering at full rate.
    initial
    begin
        wait (phase_no == 3);
        repeat (4) @(posedge clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #(10_000_000);
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------------
    // Predict on each transfer, then offer the next request or go idle. Hold
    // the payload while the block stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
        end
        else
        begin
            if (req_if.valid && req_if.ready)
                apply_request(offered);
            if (!req_if.valid || req_if.ready)
            begin
                if (requests_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    offered = requests_pending.pop_front();
                    req_if.valid     <= 1'b1;
                    req_if.operation <= offered.operation;
                    req_if.address   <= offered.address;
                    req_if.data_byte <= offered.data_byte;
                    req_if.line      <= offered.line;
                end
                else
                begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------------
    // Check each transfer against the oldest owed group, then pick the next
    // ready level.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
        end
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                if (groups_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected group: expected none, actual %h %h last %b",
                             $time, res_if.pixels_first, res_if.pixels_second, res_if.last);
                end
                else
                begin
                    wanted = groups_due.pop_front();
                    if (res_if.pixels_first !== wanted.pixels_first)
                    begin
                        errors++;
                        $display("%0t: pixels_first mismatch: expected %h, actual %h",
                                 $time, wanted.pixels_first, res_if.pixels_first);
                    end
                    if (res_if.pixels_second !== wanted.pixels_second)
                    begin
                        errors++;
                        $display("%0t: pixels_second mismatch: expected %h, actual %h",
                                 $time, wanted.pixels_second, res_if.pixels_second);
                    end
                    if (res_if.last !== wanted.last)
                    begin
                        errors++;
                        $display("%0t: last mismatch: expected %b, actual %b",
                                 $time, wanted.last, res_if.last);
                    end
                end
            end
            res_if.ready <= !hold_off && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

endmodule
